[sv/cbpt_pkg.sv]
package cbpt_pkg;

  // Default field widths of the curve datapath.
  localparam int COORD_BITS_DEF      = 24;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // Number of register stages from the input ports to the result registers.
  localparam int PIPE_DEPTH = 8;

  // One load enable for each pipeline stage, index 0 is the first stage.
  typedef logic [PIPE_DEPTH-1:0] pipe_en_t;

endpackage

[sv/cubic_bezier_point_tangent_flatness.sv]
// Cubic Bezier evaluator: point, tangent and flatness of a 2D curve.
//
// Input channel: in_valid_i with in_stall_o. One item carries the four
// control points, the parameter t (Q1.PARAM_FRAC_BITS, 1.0 is a power of two)
// and a flatness tolerance. Output channel: out_valid_o with out_stall_i; one
// result item leaves for every item taken, in order.
//
// A new item is taken in every cycle unless in_stall_o is high: the point
// chain is three Horner steps, each a registered multiply by t followed by a
// registered add, and the tangent and flatness paths run beside it in the
// same 8 stages.
//
// Each stage has its own valid bit and loads only when it is empty or the
// stage after it moves on, so a stall at the output fills the empty stages
// first and only then raises in_stall_o. Held results stay on the output
// ports until taken.
//
// Reset clears the valid bits only; the pipeline then is empty and ready.
module cubic_bezier_point_tangent_flatness #(
  parameter int COORD_BITS      = cbpt_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = cbpt_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] p0_x_i,
  input  logic signed [COORD_BITS-1:0] p0_y_i,
  input  logic signed [COORD_BITS-1:0] p1_x_i,
  input  logic signed [COORD_BITS-1:0] p1_y_i,
  input  logic signed [COORD_BITS-1:0] p2_x_i,
  input  logic signed [COORD_BITS-1:0] p2_y_i,
  input  logic signed [COORD_BITS-1:0] p3_x_i,
  input  logic signed [COORD_BITS-1:0] p3_y_i,
  input  logic [PARAM_FRAC_BITS:0]     param_t_i,
  input  logic [COORD_BITS-2:0]        tolerance_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic signed [COORD_BITS+2:0] slope_x_o,
  output logic signed [COORD_BITS+2:0] slope_y_o,
  output logic [2*COORD_BITS+4:0]      flatness_measure_o,
  output logic                         is_flat_o
);
  import cbpt_pkg::*;

  pipe_en_t en;

  // Stage valid bits and load enables.
  cbpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  // Point and tangent, one unit per axis.
  cbpt_axis #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_axis_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .q0_i    (p0_x_i),
    .q1_i    (p1_x_i),
    .q2_i    (p2_x_i),
    .q3_i    (p3_x_i),
    .t_i     (param_t_i),
    .point_o (point_x_o),
    .slope_o (slope_x_o)
  );

  cbpt_axis #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_axis_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .q0_i    (p0_y_i),
    .q1_i    (p1_y_i),
    .q2_i    (p2_y_i),
    .q3_i    (p3_y_i),
    .t_i     (param_t_i),
    .point_o (point_y_o),
    .slope_o (slope_y_o)
  );

  // Flatness measure and tolerance test.
  cbpt_flat #(
    .COORD_BITS (COORD_BITS)
  ) u_flat (
    .clk_i     (clk_i),
    .en_i      (en),
    .x0_i      (p0_x_i),
    .x1_i      (p1_x_i),
    .x2_i      (p2_x_i),
    .x3_i      (p3_x_i),
    .y0_i      (p0_y_i),
    .y1_i      (p1_y_i),
    .y2_i      (p2_y_i),
    .y3_i      (p3_y_i),
    .tol_i     (tolerance_i),
    .flat_o    (flatness_measure_o),
    .is_flat_o (is_flat_o)
  );

endmodule

[sv/cbpt_ctrl.sv]
module cbpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbpt_pkg::pipe_en_t en_o
);
  import cbpt_pkg::*;

  logic [PIPE_DEPTH-1:0] valid_d, valid_q;
  pipe_en_t              ready;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    ready[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || !out_stall_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  // Valid bits move along with the data of each item.
  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = ready;
  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[PIPE_DEPTH-1];

endmodule

[sv/cbpt_mac.sv]
module cbpt_mac #(
  parameter int XW = 28,
  parameter int TW = 17,
  parameter int OW = 46
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic [TW-1:0]        t_i,
  input  logic signed [OW-1:0] add_i,
  output logic signed [OW-1:0] y_o
);

  localparam int CH  = 32;
  localparam int NCH = (XW + CH - 1) / CH;
  localparam int PW  = CH + TW + 2;

  logic signed [NCH*CH-1:0] x_ext;
  logic signed [PW-1:0]     prod_d [NCH];
  logic signed [PW-1:0]     prod_q [NCH];
  logic signed [OW-1:0]     add_q;
  logic signed [OW-1:0]     y_d, y_q;

  assign x_ext = (NCH*CH)'(x_i);

  // First stage: one partial product for each 32-bit slice of the operand.
  // Only the top slice carries the sign.
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (i == NCH - 1) begin
        prod_d[i] = $signed(x_ext[i*CH +: CH]) * $signed({1'b0, t_i});
      end else begin
        prod_d[i] = $signed({1'b0, x_ext[i*CH +: CH]}) * $signed({1'b0, t_i});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      add_q  <= add_i;
    end
  end

  // Second stage: align the partial products and add the Horner term.
  always_comb begin
    y_d = add_q;
    for (int i = 0; i < NCH; i++) begin
      y_d = y_d + (OW'(prod_q[i]) <<< (i * CH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[sv/cbpt_axis.sv]
module cbpt_axis #(
  parameter int COORD_BITS      = cbpt_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = cbpt_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  cbpt_pkg::pipe_en_t           en_i,
  input  logic signed [COORD_BITS-1:0] q0_i,
  input  logic signed [COORD_BITS-1:0] q1_i,
  input  logic signed [COORD_BITS-1:0] q2_i,
  input  logic signed [COORD_BITS-1:0] q3_i,
  input  logic [PARAM_FRAC_BITS:0]     t_i,
  output logic signed [COORD_BITS-1:0] point_o,
  output logic signed [COORD_BITS+2:0] slope_o
);
  import cbpt_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int TW  = F + 1;
  // Accumulator widths of the point and tangent Horner chains.
  localparam int AW  = CB + 4;
  localparam int W1  = AW + F + 2;
  localparam int W2  = W1 + F + 2;
  localparam int W3  = W2 + F + 2;
  localparam int TAW = CB + 5;
  localparam int T1  = TAW + F + 2;
  localparam int T2  = T1 + F + 2;

  localparam logic signed [W3-1:0] PT_HALF = {{(W3-1){1'b0}}, 1'b1} << (3*F - 1);
  localparam logic signed [W3-1:0] PT_MAX  = {{(W3-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [W3-1:0] PT_MIN  = {{(W3-CB+1){1'b1}}, {(CB-1){1'b0}}};
  localparam logic signed [T2-1:0] TG_HALF = {{(T2-1){1'b0}}, 1'b1} << (2*F - 1);
  localparam logic signed [T2-1:0] TG_LIM  = {{(T2-2){1'b0}}, 2'b11} << CB;
  localparam logic signed [T2-1:0] TG_MAX  = TG_LIM - {{(T2-1){1'b0}}, 1'b1};
  localparam logic signed [T2-1:0] TG_MIN  = -TG_LIM;

  logic signed [AW-1:0] q0e, q1e, q2e, q3e;
  logic signed [AW-1:0] a_d, b_d, c_d;
  logic signed [AW-1:0] a_q, b_q, c_q1, c_q2, c_q3;
  logic signed [CB-1:0] q0_q1, q0_q2, q0_q3, q0_q4, q0_q5;
  logic [TW-1:0]        t_q1, t_q2, t_q3, t_q4, t_q5;

  logic signed [TAW-1:0] a3;
  logic signed [W1-1:0]  pt_acc1;
  logic signed [W2-1:0]  pt_acc2;
  logic signed [W3-1:0]  pt_acc3;
  logic signed [T1-1:0]  tg_acc1;
  logic signed [T2-1:0]  tg_acc2;

  logic signed [W3-1:0]   pt_sum, pt_sh;
  logic signed [T2-1:0]   tg_sum, tg_sh;
  logic signed [CB-1:0]   point_d, point_q;
  logic signed [CB+2:0]   slope_d, slope_q6, slope_q7, slope_q8;

  // Power-basis coefficients from the control points.
  assign q0e = AW'(q0_i);
  assign q1e = AW'(q1_i);
  assign q2e = AW'(q2_i);
  assign q3e = AW'(q3_i);
  assign a_d = q3e - ((q2e <<< 1) + q2e) + ((q1e <<< 1) + q1e) - q0e;
  assign b_d = ((q2e <<< 1) + q2e) - ((q1e <<< 2) + (q1e <<< 1)) + ((q0e <<< 1) + q0e);
  assign c_d = ((q1e <<< 1) + q1e) - ((q0e <<< 1) + q0e);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q1  <= c_d;
      q0_q1 <= q0_i;
      t_q1  <= t_i;
    end
    if (en_i[1]) begin
      c_q2  <= c_q1;
      q0_q2 <= q0_q1;
      t_q2  <= t_q1;
    end
    if (en_i[2]) begin
      c_q3  <= c_q2;
      q0_q3 <= q0_q2;
      t_q3  <= t_q2;
    end
    if (en_i[3]) begin
      q0_q4 <= q0_q3;
      t_q4  <= t_q3;
    end
    if (en_i[4]) begin
      q0_q5 <= q0_q4;
      t_q5  <= t_q4;
    end
  end

  assign a3 = TAW'(a_q) + (TAW'(a_q) <<< 1);

  // First Horner step: point a*t + b, tangent 3a*t + 2b.
  cbpt_mac #(.XW(AW), .TW(TW), .OW(W1)) u_pt_mac1 (
    .clk_i (clk_i),
    .en_i  (en_i[2:1]),
    .x_i   (a_q),
    .t_i   (t_q1),
    .add_i (W1'(b_q) <<< F),
    .y_o   (pt_acc1)
  );

  cbpt_mac #(.XW(TAW), .TW(TW), .OW(T1)) u_tg_mac1 (
    .clk_i (clk_i),
    .en_i  (en_i[2:1]),
    .x_i   (a3),
    .t_i   (t_q1),
    .add_i (T1'(b_q) <<< (F + 1)),
    .y_o   (tg_acc1)
  );

  // Second Horner step adds c for both chains.
  cbpt_mac #(.XW(W1), .TW(TW), .OW(W2)) u_pt_mac2 (
    .clk_i (clk_i),
    .en_i  (en_i[4:3]),
    .x_i   (pt_acc1),
    .t_i   (t_q3),
    .add_i (W2'(c_q3) <<< (2*F)),
    .y_o   (pt_acc2)
  );

  cbpt_mac #(.XW(T1), .TW(TW), .OW(T2)) u_tg_mac2 (
    .clk_i (clk_i),
    .en_i  (en_i[4:3]),
    .x_i   (tg_acc1),
    .t_i   (t_q3),
    .add_i (T2'(c_q3) <<< (2*F)),
    .y_o   (tg_acc2)
  );

  // Third Horner step adds the start point, for the point chain only.
  cbpt_mac #(.XW(W2), .TW(TW), .OW(W3)) u_pt_mac3 (
    .clk_i (clk_i),
    .en_i  (en_i[6:5]),
    .x_i   (pt_acc2),
    .t_i   (t_q5),
    .add_i (W3'(q0_q5) <<< (3*F)),
    .y_o   (pt_acc3)
  );

  // Tangent rounding to nearest, ties upward, then saturation.
  always_comb begin
    tg_sum = tg_acc2 + TG_HALF;
    tg_sh  = tg_sum >>> (2*F);
    if (tg_sh > TG_MAX) begin
      slope_d = TG_MAX[CB+2:0];
    end else if (tg_sh < TG_MIN) begin
      slope_d = TG_MIN[CB+2:0];
    end else begin
      slope_d = tg_sh[CB+2:0];
    end
  end

  // Point rounding to nearest, ties upward, then saturation.
  always_comb begin
    pt_sum = pt_acc3 + PT_HALF;
    pt_sh  = pt_sum >>> (3*F);
    if (pt_sh > PT_MAX) begin
      point_d = PT_MAX[CB-1:0];
    end else if (pt_sh < PT_MIN) begin
      point_d = PT_MIN[CB-1:0];
    end else begin
      point_d = pt_sh[CB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      slope_q6 <= slope_d;
    end
    if (en_i[6]) begin
      slope_q7 <= slope_q6;
    end
    if (en_i[7]) begin
      slope_q8 <= slope_q7;
      point_q  <= point_d;
    end
  end

  assign point_o = point_q;
  assign slope_o = slope_q8;

endmodule

[sv/cbpt_flat.sv]
module cbpt_flat #(
  parameter int COORD_BITS = cbpt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  cbpt_pkg::pipe_en_t           en_i,
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] x2_i,
  input  logic signed [COORD_BITS-1:0] x3_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  input  logic signed [COORD_BITS-1:0] y2_i,
  input  logic signed [COORD_BITS-1:0] y3_i,
  input  logic [COORD_BITS-2:0]        tol_i,
  output logic [2*COORD_BITS+4:0]      flat_o,
  output logic                         is_flat_o
);
  import cbpt_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 3;
  localparam int MGW  = CB + 2;
  localparam int MW   = (MGW > 32) ? 32 : MGW;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 1;
  localparam int FW   = 2 * CB + 5;
  localparam int EW   = (SUMW > FW) ? SUMW : FW;
  localparam int LW   = (FW > 64) ? 64 : FW;
  localparam int TOLW = CB - 1;
  localparam int TLW  = (TOLW > 30) ? 30 : TOLW;
  localparam int LMW  = 2 * TLW + 4;
  localparam int CMPW = (LW > LMW) ? LW : LMW;
  localparam int NDLY = PIPE_DEPTH - 4;

  logic signed [DW-1:0] e0 [2];
  logic signed [DW-1:0] e1 [2];
  logic signed [DW-1:0] e2 [2];
  logic signed [DW-1:0] e3 [2];
  logic signed [DW-1:0] dev_d [2][2];
  logic signed [DW-1:0] dev_q [2][2];
  logic [TOLW-1:0]      tol_q1;

  logic [MGW-1:0] mag [2][2];
  logic [MW-1:0]  mlo [2][2];
  logic [SQW-1:0] sq_d [2][2];
  logic [SQW-1:0] sq_q [2][2];
  logic [TLW-1:0] tol_lo;
  logic           tbig_d, tbig_q2;
  logic [2*TLW-1:0] tsq_d, tsq_q2;

  logic [SQW-1:0] mx [2];
  logic [EW-1:0]  sum_d, sum_q3;
  logic [LMW-1:0] lim_d, lim_q3;

  logic [LW-1:0]  flat_lw;
  logic [FW-1:0]  flat_d;
  logic           is_flat_d;
  logic [FW-1:0]  flat_q [NDLY+1];
  logic           is_flat_q [NDLY+1];

  // Deviations of the inner control points from the chord, per axis.
  assign e0[0] = DW'(x0_i);
  assign e1[0] = DW'(x1_i);
  assign e2[0] = DW'(x2_i);
  assign e3[0] = DW'(x3_i);
  assign e0[1] = DW'(y0_i);
  assign e1[1] = DW'(y1_i);
  assign e2[1] = DW'(y2_i);
  assign e3[1] = DW'(y3_i);

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      dev_d[j][0] = ((e1[j] <<< 1) + e1[j]) - (e0[j] <<< 1) - e3[j];
      dev_d[j][1] = ((e2[j] <<< 1) + e2[j]) - (e3[j] <<< 1) - e0[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dev_q  <= dev_d;
      tol_q1 <= tol_i;
    end
  end

  // Squares, forced to all ones when the magnitude reaches 2^MW (MW is at most 32).
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 2; k++) begin
        mag[j][k] = MGW'(dev_q[j][k][DW-1] ? -dev_q[j][k] : dev_q[j][k]);
        mlo[j][k] = mag[j][k][MW-1:0];
        if ((mag[j][k] >> MW) != '0) begin
          sq_d[j][k] = '1;
        end else begin
          sq_d[j][k] = SQW'(mlo[j][k]) * SQW'(mlo[j][k]);
        end
      end
    end
  end

  // Squared tolerance, with the same saturation rule at 2^TLW (TLW is at most 30).
  assign tol_lo = tol_q1[TLW-1:0];
  assign tbig_d = (tol_q1 >> TLW) != '0;
  assign tsq_d  = (2*TLW)'(tol_lo) * (2*TLW)'(tol_lo);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sq_q    <= sq_d;
      tbig_q2 <= tbig_d;
      tsq_q2  <= tsq_d;
    end
  end

  // Larger square per axis, summed over both axes; limit is 16 tol^2.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      mx[j] = (sq_q[j][0] < sq_q[j][1]) ? sq_q[j][1] : sq_q[j][0];
    end
    sum_d = EW'(mx[0]) + EW'(mx[1]);
    lim_d = tbig_q2 ? {LMW{1'b1}} : {tsq_q2, 4'b0000};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sum_q3 <= sum_d;
      lim_q3 <= lim_d;
    end
  end

  // Clamp the measure to its range, then compare with the limit.
  always_comb begin
    if ((sum_q3 >> LW) != '0) begin
      flat_lw = '1;
    end else begin
      flat_lw = sum_q3[LW-1:0];
    end
    flat_d    = FW'(flat_lw);
    is_flat_d = CMPW'(flat_lw) <= CMPW'(lim_q3);
  end

  // Carry the result along to line up with the point and tangent.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      flat_q[0]    <= flat_d;
      is_flat_q[0] <= is_flat_d;
    end
    for (int k = 1; k <= NDLY; k++) begin
      if (en_i[3+k]) begin
        flat_q[k]    <= flat_q[k-1];
        is_flat_q[k] <= is_flat_q[k-1];
      end
    end
  end

  assign flat_o    = flat_q[NDLY];
  assign is_flat_o = is_flat_q[NDLY];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  import cbpt_pkg::*;

  localparam int CB      = COORD_BITS_DEF;
  localparam int PF      = PARAM_FRAC_BITS_DEF;
  localparam int LATENCY = PIPE_DEPTH;

  localparam longint CMAX      = (longint'(1) << (CB - 1)) - 1;
  localparam longint CMIN      = -(longint'(1) << (CB - 1));
  localparam longint TOL_MAX   = (longint'(1) << (CB - 1)) - 1;
  localparam longint SLOPE_MAX = 3 * (longint'(1) << CB) - 1;
  localparam longint SLOPE_MIN = -3 * (longint'(1) << CB);
  localparam int     ONE_T     = 1 << PF;

  localparam logic [127:0] FLAT_MASK = (128'd1 << (2 * CB + 5)) - 1;

  localparam int N_RANDOM    = 1030;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 800;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic signed [CB-1:0] p0_x;
    logic signed [CB-1:0] p0_y;
    logic signed [CB-1:0] p1_x;
    logic signed [CB-1:0] p1_y;
    logic signed [CB-1:0] p2_x;
    logic signed [CB-1:0] p2_y;
    logic signed [CB-1:0] p3_x;
    logic signed [CB-1:0] p3_y;
    logic [PF:0]          t;
    logic [CB-2:0]        tol;
  } curve_t;

  typedef struct packed {
    logic signed [CB-1:0] point_x;
    logic signed [CB-1:0] point_y;
    logic signed [CB+2:0] slope_x;
    logic signed [CB+2:0] slope_y;
    logic [2*CB+4:0]      flat;
    logic                 flag;
  } sample_t;

  // A known answer, if any, travels with each item from the driver to the checker.
  typedef struct packed {
    logic    typed;
    sample_t res;
  } answer_t;

  typedef struct {
    curve_t  stim;
    logic    typed;
    sample_t res;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic signed [CB-1:0] p0_x_i      = '0;
  logic signed [CB-1:0] p0_y_i      = '0;
  logic signed [CB-1:0] p1_x_i      = '0;
  logic signed [CB-1:0] p1_y_i      = '0;
  logic signed [CB-1:0] p2_x_i      = '0;
  logic signed [CB-1:0] p2_y_i      = '0;
  logic signed [CB-1:0] p3_x_i      = '0;
  logic signed [CB-1:0] p3_y_i      = '0;
  logic [PF:0]          param_t_i   = '0;
  logic [CB-2:0]        tolerance_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [CB-1:0] point_x_o;
  logic signed [CB-1:0] point_y_o;
  logic signed [CB+2:0] slope_x_o;
  logic signed [CB+2:0] slope_y_o;
  logic [2*CB+4:0]      flatness_measure_o;
  logic                 is_flat_o;

  int send_idle_pct  = 17;
  int recv_stall_pct = 81;
  int accepted_count = 0;
  int result_count   = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  bit hold_done      = 1'b0;

  answer_t row_answer_q[$];
  sample_t due_samples[$];
  row_t    dir_rows[$];

  cubic_bezier_point_tangent_flatness dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .p0_x_i             (p0_x_i),
    .p0_y_i             (p0_y_i),
    .p1_x_i             (p1_x_i),
    .p1_y_i             (p1_y_i),
    .p2_x_i             (p2_x_i),
    .p2_y_i             (p2_y_i),
    .p3_x_i             (p3_x_i),
    .p3_y_i             (p3_y_i),
    .param_t_i          (param_t_i),
    .tolerance_i        (tolerance_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .point_x_o          (point_x_o),
    .point_y_o          (point_y_o),
    .slope_x_o          (slope_x_o),
    .slope_y_o          (slope_y_o),
    .flatness_measure_o (flatness_measure_o),
    .is_flat_o          (is_flat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shift right by s with round half up, then clamp to [lo, hi].
  function automatic logic signed [127:0] round_clamp(input logic signed [127:0] x,
                                                      input int s,
                                                      input logic signed [127:0] lo,
                                                      input logic signed [127:0] hi);
    logic signed [127:0] y;
    y = (x + (128'sd1 <<< (s - 1))) >>> s;
    if (y < lo) return lo;
    if (y > hi) return hi;
    return y;
  endfunction

  // One axis: point and tangent by Horner steps on exact wide values, and
  // the larger squared deviation of the two inner control points.
  function automatic void eval_axis(input logic signed [CB-1:0] q0, q1, q2, q3,
                                    input logic [PF:0] t,
                                    output logic signed [CB-1:0] pt,
                                    output logic signed [CB+2:0] sl,
                                    output logic [127:0] dev);
    logic signed [127:0] s0, s1, s2, s3, tw, a, b, lin, acc, u, v;
    logic [127:0] uu, vv;
    s0 = 128'(q0);
    s1 = 128'(q1);
    s2 = 128'(q2);
    s3 = 128'(q3);
    tw = 128'(t);
    a = s3 - 3 * s2 + 3 * s1 - s0;
    b = 3 * s2 - 6 * s1 + 3 * s0;
    lin = 3 * s1 - 3 * s0;

    acc = a * tw + (b <<< PF);
    acc = acc * tw + (lin <<< (2 * PF));
    acc = acc * tw + (s0 <<< (3 * PF));
    pt = CB'(round_clamp(acc, 3 * PF, 128'(CMIN), 128'(CMAX)));

    acc = 3 * a * tw + ((2 * b) <<< PF);
    acc = acc * tw + (lin <<< (2 * PF));
    sl = (CB+3)'(round_clamp(acc, 2 * PF, 128'(SLOPE_MIN), 128'(SLOPE_MAX)));

    u = 3 * s1 - 2 * s0 - s3;
    v = 3 * s2 - 2 * s3 - s0;
    uu = u * u;
    vv = v * v;
    dev = (uu < vv) ? vv : uu;
  endfunction

  // Expected sample for one curve item.
  function automatic sample_t eval_curve(input curve_t c);
    sample_t r;
    logic signed [CB-1:0] px, py;
    logic signed [CB+2:0] sx, sy;
    logic [127:0] dx, dy, sum, lim;
    eval_axis(c.p0_x, c.p1_x, c.p2_x, c.p3_x, c.t, px, sx, dx);
    eval_axis(c.p0_y, c.p1_y, c.p2_y, c.p3_y, c.t, py, sy, dy);
    sum = dx + dy;
    lim = (128'(c.tol) * 128'(c.tol)) << 4;
    r.point_x = px;
    r.point_y = py;
    r.slope_x = sx;
    r.slope_y = sy;
    r.flat = (2*CB+5)'((sum > FLAT_MASK) ? FLAT_MASK : sum);
    r.flag = ({75'd0, r.flat} <= lim);
    return r;
  endfunction

  function automatic curve_t mk_curve(input longint x0, y0, x1, y1, x2, y2, x3, y3,
                                      input longint t, tol);
    curve_t c;
    c.p0_x = CB'(x0);
    c.p0_y = CB'(y0);
    c.p1_x = CB'(x1);
    c.p1_y = CB'(y1);
    c.p2_x = CB'(x2);
    c.p2_y = CB'(y2);
    c.p3_x = CB'(x3);
    c.p3_y = CB'(y3);
    c.t = (PF+1)'(t);
    c.tol = (CB-1)'(tol);
    return c;
  endfunction

  function automatic sample_t mk_result(input longint px, py, sx, sy, flat, flag);
    sample_t r;
    r.point_x = CB'(px);
    r.point_y = CB'(py);
    r.slope_x = (CB+3)'(sx);
    r.slope_y = (CB+3)'(sy);
    r.flat = (2*CB+5)'(flat);
    r.flag = flag[0];
    return r;
  endfunction

  // One row of the directed table.
  function automatic void add_row(input curve_t stim, input logic typed,
                                  input sample_t res);
    row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Local modes cluster the points around a base, which keeps the flatness
  // small and near the tolerance; the other modes use full range and extremes.
  function automatic logic signed [CB-1:0] pick_coord(input int mode,
                                                      input logic signed [CB-1:0] base,
                                                      input int sh);
    int off;
    if (mode < 5) begin
      off = int'($urandom & ((32'd1 << sh) - 1)) - (1 << (sh - 1));
      return CB'(base + off);
    end
    if (mode < 8 || $urandom_range(1) == 0) return CB'($urandom);
    case ($urandom_range(4))
      0: return CB'(CMIN);
      1: return CB'(CMAX);
      2: return '0;
      3: return '1;
      default: return CB'(1);
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    sample_t s;
    int mode, sh, pick, tol;
    logic signed [CB-1:0] bx, by;
    real r;
    mode = $urandom_range(9);
    sh = $urandom_range(1, 16);
    bx = CB'($urandom);
    by = CB'($urandom);
    c.p0_x = pick_coord(mode, bx, sh);
    c.p0_y = pick_coord(mode, by, sh);
    c.p1_x = pick_coord(mode, bx, sh);
    c.p1_y = pick_coord(mode, by, sh);
    c.p2_x = pick_coord(mode, bx, sh);
    c.p2_y = pick_coord(mode, by, sh);
    c.p3_x = pick_coord(mode, bx, sh);
    c.p3_y = pick_coord(mode, by, sh);

    // Mostly inside [0, 1], some at the ends, a few past one.
    pick = $urandom_range(99);
    if (pick < 3) begin
      c.t = (PF+1)'($urandom_range(ONE_T + 1, 2 * ONE_T - 1));
    end else if (pick < 13) begin
      case ($urandom_range(4))
        0: c.t = '0;
        1: c.t = (PF+1)'(1);
        2: c.t = (PF+1)'(ONE_T / 2);
        3: c.t = (PF+1)'(ONE_T - 1);
        default: c.t = (PF+1)'(ONE_T);
      endcase
    end else begin
      c.t = (PF+1)'($urandom_range(0, ONE_T));
    end

    // A third of the tolerances sit right at the flatness threshold.
    pick = $urandom_range(2);
    if (pick == 0) begin
      c.tol = '0;
      s = eval_curve(c);
      r = $sqrt(real'(s.flat)) / 4.0;
      tol = $rtoi(r) + int'($urandom_range(2)) - 1;
      if (tol < 0) tol = 0;
      if (tol > TOL_MAX) tol = int'(TOL_MAX);
      c.tol = (CB-1)'(tol);
    end else if (pick == 1) begin
      c.tol = (CB-1)'($urandom);
    end else begin
      c.tol = (CB-1)'($urandom & ((32'd1 << $urandom_range(23)) - 1));
    end
    return c;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got, want);
    if (got !== want) begin
      note_error($sformatf("sample %0d %s: expected %0d, got %0d",
                           result_count, name, want, got));
    end
  endtask

  // Offer one item after a random idle gap and hold it until it is taken.
  task automatic offer(input curve_t c, input logic typed, input sample_t ans);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    p0_x_i <= c.p0_x;
    p0_y_i <= c.p0_y;
    p1_x_i <= c.p1_x;
    p1_y_i <= c.p1_y;
    p2_x_i <= c.p2_x;
    p2_y_i <= c.p2_y;
    p3_x_i <= c.p3_x;
    p3_y_i <= c.p3_y;
    param_t_i <= c.t;
    tolerance_i <= c.tol;
    in_valid_i <= 1'b1;
    row_answer_q.insert(row_answer_q.size(), answer_t'{typed, ans});
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output stall: random, with one long hold-off once the run is well along
  // so that the pipeline fills and pushes back on the input.
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk_i);
      if (!hold_done && accepted_count >= HOLD_AT) begin
        hold_done = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Take the known answer or a prediction for every accepted item, and compare every accepted sample.
  always @(posedge clk_i) begin : scoreboard
    answer_t ans;
    sample_t want;
    curve_t  c;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        ans = row_answer_q.pop_front();
        c = '{p0_x_i, p0_y_i, p1_x_i, p1_y_i, p2_x_i, p2_y_i, p3_x_i, p3_y_i,
              param_t_i, tolerance_i};
        want = ans.typed ? ans.res : eval_curve(c);
        due_samples.insert(due_samples.size(), want);
        accepted_count <= accepted_count + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_samples.size() == 0) begin
          note_error($sformatf("sample %0d arrived with nothing expected", result_count));
        end else begin
          want = due_samples.pop_front();
          check_field("point_x", 64'(point_x_o), 64'(want.point_x));
          check_field("point_y", 64'(point_y_o), 64'(want.point_y));
          check_field("slope_x", 64'(slope_x_o), 64'(want.slope_x));
          check_field("slope_y", 64'(slope_y_o), 64'(want.slope_y));
          check_field("flatness_measure", 64'(flatness_measure_o), 64'(want.flat));
          check_field("is_flat", 64'(is_flat_o), 64'(want.flag));
        end
        result_count++;
      end
    end
  end

  initial begin : stimulus
    curve_t c;
    int     i;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items; the known answers follow from the curve shape.
    // Degenerate curves: every control point equal.
    add_row(mk_curve(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_result(0, 0, 0, 0, 0, 1));
    add_row(mk_curve(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, ONE_T, 0),
            1'b1, mk_result(CMAX, CMAX, 0, 0, 0, 1));
    add_row(mk_curve(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, ONE_T / 2,
                     TOL_MAX), 1'b1, mk_result(CMIN, CMIN, 0, 0, 0, 1));
    // Evenly spaced straight line: the point moves linearly, the tangent is fixed.
    add_row(mk_curve(0, 0, 256, 0, 512, 0, 768, 0, 0, 0), 1'b1,
            mk_result(0, 0, 768, 0, 0, 1));
    add_row(mk_curve(0, 0, 256, 0, 512, 0, 768, 0, ONE_T / 2, 0), 1'b1,
            mk_result(384, 0, 768, 0, 0, 1));
    add_row(mk_curve(0, 0, 256, 0, 512, 0, 768, 0, ONE_T, 0), 1'b1,
            mk_result(768, 0, 768, 0, 0, 1));
    // Exact half-LSB points round up, on both signs.
    add_row(mk_curve(0, 0, 1, 0, 2, 0, 3, 0, ONE_T / 2, 0), 1'b1,
            mk_result(2, 0, 3, 0, 0, 1));
    add_row(mk_curve(0, 0, 0, -1, 0, -2, 0, -3, ONE_T / 2, 0), 1'b1,
            mk_result(0, -1, 0, -3, 0, 1));
    // Flatness of 144 against tolerance 3 (equal limit) and tolerance 2.
    add_row(mk_curve(0, 0, 4, 0, 0, 0, 0, 0, 0, 3), 1'b1,
            mk_result(0, 0, 12, 0, 144, 1));
    add_row(mk_curve(0, 0, 4, 0, 0, 0, 0, 0, 0, 2), 1'b1,
            mk_result(0, 0, 12, 0, 144, 0));
    // Full-swing zigzag: largest deviation on both axes, endpoints exact.
    add_row(mk_curve(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, ONE_T,
                     TOL_MAX), 1'b1,
            mk_result(CMAX, CMAX, 3 * (CMAX - CMIN), 3 * (CMAX - CMIN),
                      64'sd2251799545249800, 0));
    add_row(mk_curve(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 0, 0), 1'b1,
            mk_result(CMIN, CMIN, 3 * (CMAX - CMIN), 3 * (CMAX - CMIN),
                      64'sd2251799545249800, 0));
    // Extrapolation past one, in some rows far enough to drive point and tangent into saturation.
    add_row(mk_curve(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN,
                     2 * ONE_T - 1, 0), 1'b0, '0);
    add_row(mk_curve(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX,
                     2 * ONE_T - 1, TOL_MAX), 1'b0, '0);
    add_row(mk_curve(0, 0, 1000, -2000, -3000, 4000, 5000, -6000, ONE_T + 1, 77),
            1'b0, '0);
    add_row(mk_curve(-5, 7, 100000, -90000, -70000, 3, 12345, -54321, 2 * ONE_T - 1,
                     1), 1'b0, '0);
    // Parameter just off the ends, and odd patterns in every field.
    add_row(mk_curve(CMIN, CMAX, CMAX, CMIN, 0, 0, -1, 1, 1, TOL_MAX), 1'b0, '0);
    add_row(mk_curve(CMAX, CMIN, 0, -1, CMIN, CMAX, 1, 0, ONE_T - 1, 4096),
            1'b0, '0);
    add_row(mk_curve(-1, -1, -1, -1, -1, -1, -1, -1, ONE_T - 1, TOL_MAX), 1'b0, '0);
    add_row(mk_curve(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 24'h555555,
                     24'haaaaaa, 24'haaaaaa, 24'h555555, 17'h0aaaa, 23'h2aaaaa),
            1'b0, '0);
    add_row(mk_curve(300, -200, 1200, 900, -800, 1500, 2000, -100, 12345, 256),
            1'b0, '0);

    foreach (dir_rows[k]) offer(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].res);

    // Random items in three idling phases.
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct <= 81;
        recv_stall_pct <= 17;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
      end
      c = random_curve();
      offer(c, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    // Drain the pipeline, then give stray samples time to show up.
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (due_samples.size() != 0) begin
      note_error($sformatf("%0d expected samples never arrived", due_samples.size()));
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cbpt_pkg.sv
sv/cbpt_ctrl.sv
sv/cbpt_mac.sv
sv/cbpt_axis.sv
sv/cbpt_flat.sv
sv/cubic_bezier_point_tangent_flatness.sv
tb/tb_top.sv
